@@ rtl/vgpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgpd_pkg: shared definitions for the voxel grid point deduplicator
// Field widths, hash primes, the cell size reset value and the sequencer state type.
// ----------------------------------------------------------------------------
package vgpd_pkg;

  localparam int COORD_W    = 28;
  localparam int CELL_W     = 20;
  localparam int KEY_W      = 64;
  localparam int PRIME_W    = 27;
  localparam int CIDX_W     = COORD_W + 1;
  localparam int PROD_W     = CIDX_W + PRIME_W + 1;
  localparam int TDATA_W    = 88;
  localparam int SEEN_DEPTH_DEF = 1024;

  localparam logic [CELL_W-1:0]  CELL_RESET = CELL_W'(5000);
  localparam logic [PRIME_W-1:0] PRIME_X    = PRIME_W'(73856093);
  localparam logic [PRIME_W-1:0] PRIME_Y    = PRIME_W'(19349663);
  localparam logic [PRIME_W-1:0] PRIME_Z    = PRIME_W'(83492791);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL,
    ST_ACC,
    ST_SCAN,
    ST_INSERT,
    ST_OUT
  } vgpd_state_t;

endpackage

@@ rtl/vgpd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgpd_div: radix-2 restoring divider
// Unsigned coordinate magnitude over cell size, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vgpd_div
  import vgpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] dividend,
  input  logic [CELL_W-1:0]  divisor,
  output logic               done,
  output logic [COORD_W-1:0] quotient,
  output logic               rem_nz
);

  localparam int CNT_W = $clog2(COORD_W);

  logic [CELL_W-1:0]  rem;
  logic [CELL_W-1:0]  dvs;
  logic [COORD_W-1:0] quo;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [CELL_W:0]    shifted;
  logic               ge;

  assign shifted  = {rem, quo[COORD_W-1]};
  assign ge       = shifted >= {1'b0, dvs};
  assign quotient = quo;
  assign rem_nz   = |rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(COORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? CELL_W'(shifted - {1'b0, dvs}) : shifted[CELL_W-1:0];
      quo <= {quo[COORD_W-2:0], ge};
    end
  end

endmodule

@@ rtl/voxel_grid_point_dedup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_grid_point_dedup: voxel grid spatial hash deduplication
// Maps each point to a voxel cell, hashes the cell and flags repeats per frame.
// ----------------------------------------------------------------------------
// Sequence: for each of the three axes a floor division and a hash step,
// then a scan of the key table over the keys stored so far in this frame,
// then an insert when the key is not found, then the result is presented.
// Throughput: one point at a time; the next point is taken once the result
// transfer completes. The table scan (one memory read per cycle) dominates.
// Reset clears the sequencer and the fill count; the table needs no clearing.
module voxel_grid_point_dedup
  import vgpd_pkg::*;
#(
  parameter int SEEN_DEPTH = SEEN_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration: cell_size_um.
  input  logic               cfg_we,
  input  logic [CELL_W-1:0]  cfg_wdata,
  // Input points. tdata: x_um[27:0], y_um[55:28], z_um[83:56], zero fill.
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,
  input  logic               s_tlast,    // frame_end
  // Results. tdata: out_x_um[27:0], out_y_um[55:28], out_z_um[83:56], zero fill.
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic [1:0]         m_tuser,    // kept[0], table_full[1]
  output logic               m_tlast     // frame_done
);

  localparam int ADDR_W = $clog2(SEEN_DEPTH);
  localparam int CNT_W  = ADDR_W + 1;

  // Configuration register.
  logic [CELL_W-1:0] cell_size;
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CELL_RESET;
    end else if (cfg_we) begin
      cell_size <= cfg_wdata;
    end
  end

  // Point held for the whole computation and passed through on output.
  logic signed [COORD_W-1:0] px, py, pz;
  logic                      fend;

  vgpd_state_t state, state_next;
  logic [1:0]  axis;
  logic        kept, full;
  logic [KEY_W-1:0] key;
  logic signed [CIDX_W-1:0] cidx;
  logic signed [PROD_W-1:0] prod;

  // Key table: entries 0..count-1 hold this frame's keys in insert order,
  // so the fill count alone says which entries are valid.
  logic [KEY_W-1:0]  seen_mem [SEEN_DEPTH];
  logic [KEY_W-1:0]  rd_data;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  scan_idx;
  logic              cmp_vld;
  logic              rd_en;
  logic              hit;
  logic              at_end;

  // Divider hookup: magnitude of the current axis over the cell size.
  logic signed [COORD_W-1:0] cur;
  logic [COORD_W-1:0]        mag;
  logic [CELL_W-1:0]         dvs;
  logic                      div_done, div_rnz;
  logic [COORD_W-1:0]        div_q;
  logic [PRIME_W-1:0]        prime;

  always_comb begin
    case (axis)
      2'd0:    begin cur = px; prime = PRIME_X; end
      2'd1:    begin cur = py; prime = PRIME_Y; end
      default: begin cur = pz; prime = PRIME_Z; end
    endcase
  end

  assign mag = cur[COORD_W-1] ? COORD_W'(-cur) : COORD_W'(cur);
  // A zero cell size acts as one.
  assign dvs = (cell_size == '0) ? CELL_W'(1) : cell_size;

  vgpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIV_START),
    .dividend (mag),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_rnz)
  );

  assign hit    = cmp_vld && (rd_data == key);
  assign at_end = (scan_idx == count);
  assign rd_en  = (state == ST_SCAN) && !hit && !at_end;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= seen_mem[scan_idx[ADDR_W-1:0]];
    end
    if (state == ST_INSERT && count != CNT_W'(SEEN_DEPTH)) begin
      seen_mem[count[ADDR_W-1:0]] <= key;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_next = ST_MUL;
      ST_MUL:       state_next = ST_ACC;
      ST_ACC:       state_next = (axis == 2'd2) ? ST_SCAN : ST_DIV_START;
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_OUT;
        end else if (at_end) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT:    state_next = ST_OUT;
      ST_OUT:       if (m_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INSERT && count != CNT_W'(SEEN_DEPTH)) begin
        count <= count + 1'b1;
      end
      // The frame's last point resets the fill count once its result is taken.
      if (state == ST_OUT && m_tready && fend) begin
        count <= '0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        px   <= s_tdata[COORD_W-1:0];
        py   <= s_tdata[2*COORD_W-1:COORD_W];
        pz   <= s_tdata[3*COORD_W-1:2*COORD_W];
        fend <= s_tlast;
        axis <= 2'd0;
        key  <= '0;
      end
      ST_DIV_WAIT: begin
        // Floor division: negative values with a remainder round down.
        if (cur[COORD_W-1]) begin
          cidx <= -$signed({1'b0, div_q}) - $signed(CIDX_W'(div_rnz));
        end else begin
          cidx <= $signed({1'b0, div_q});
        end
      end
      ST_MUL: begin
        prod <= cidx * $signed({1'b0, prime});
      end
      ST_ACC: begin
        key      <= key ^ KEY_W'(prod);
        axis     <= axis + 2'd1;
        scan_idx <= '0;
        cmp_vld  <= 1'b0;
      end
      ST_SCAN: begin
        cmp_vld <= rd_en;
        if (rd_en) begin
          scan_idx <= scan_idx + 1'b1;
        end
        kept <= !hit;
        full <= 1'b0;
      end
      ST_INSERT: begin
        full <= (count == CNT_W'(SEEN_DEPTH));
      end
      default: ;
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {{(TDATA_W - 3*COORD_W){1'b0}}, pz, py, px};
  assign m_tuser  = {full, kept};
  assign m_tlast  = fend;

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SEEN_DEPTH)) else $error("fill count beyond table depth");

  a_full_kept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0]) else $error("table_full without kept");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> count == '0)
    else $error("table not cleared at frame end");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input taken while result pending");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the voxel grid point deduplicator
// Streams 3-D points through the block under several cell sizes, predicts the
// kept, table_full and pass-through fields per point and compares every result.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic        kept;
  logic [27:0] x;
  logic [27:0] y;
  logic [27:0] z;
  logic        frame_done;
  logic        table_full;
} dedup_result_t;

// Scoreboard: keeps its own copy of the per-frame key table and the cell size.
class dedup_scoreboard;
  longint unsigned frame_keys[$];
  dedup_result_t   expected_q[$];
  int unsigned     cell_um;
  int              errors;
  int              n_kept, n_dup, n_full, n_frames, n_checked;

  function new();
    cell_um = 5000;
  endfunction

  // Floor division of a signed coordinate by the cell edge.
  function longint unsigned voxel_index(logic signed [27:0] c, longint d);
    longint v;
    longint q;
    v = c;
    q = v / d;
    if ((v % d) != 0 && v < 0) q = q - 1;
    return q;
  endfunction

  function void note_point(logic [27:0] x, logic [27:0] y, logic [27:0] z,
                           logic fe);
    longint          d;
    longint unsigned hash;
    dedup_result_t   r;
    bit              hit;
    d = (cell_um == 0) ? 1 : cell_um;
    hash = (voxel_index(x, d) * 64'd73856093) ^ (voxel_index(y, d) * 64'd19349663)
         ^ (voxel_index(z, d) * 64'd83492791);
    hit = 0;
    foreach (frame_keys[i]) if (frame_keys[i] == hash) hit = 1;
    r.kept = !hit;
    r.table_full = 0;
    if (!hit) begin
      if (frame_keys.size() < 1024) frame_keys.push_back(hash);
      else r.table_full = 1;
    end
    r.x = x;
    r.y = y;
    r.z = z;
    r.frame_done = fe;
    expected_q.push_back(r);
    if (fe) frame_keys.delete();
  endfunction

  function void check_result(dedup_result_t got);
    dedup_result_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    n_checked++;
    if (got !== e) begin
      $display("%0t: expected %0b/%h/%h/%h/%0b/%0b actual %0b/%h/%h/%h/%0b/%0b",
               $time, e.kept, e.x, e.y, e.z, e.frame_done, e.table_full,
               got.kept, got.x, got.y, got.z, got.frame_done, got.table_full);
      errors++;
    end
    if (e.kept) n_kept++; else n_dup++;
    if (e.table_full) n_full++;
    if (e.frame_done) n_frames++;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb;
  import vgpd_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [CELL_W-1:0]  cfg_wdata = '0;
  logic               s_tvalid = 0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               s_tlast = 0;
  logic               m_tvalid;
  logic               m_tready = 0;
  logic [TDATA_W-1:0] m_tdata;
  logic [1:0]         m_tuser;
  logic               m_tlast;

  dedup_scoreboard sb = new();

  // Both sides idle at random unless a quiet stretch is running.
  bit quiet = 0;
  // The stimulus raises this once to ask the receiver for a long hold-off.
  bit hold_req = 0;
  bit hold_taken = 0;
  int hold_left = 0;

  // Recent points, reused with small offsets so that cells repeat.
  logic [27:0] pool_x[$], pool_y[$], pool_z[$];

  always #1 clk = ~clk;

  voxel_grid_point_dedup u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  // Receiver: the ready line changes on the falling edge. The long hold-off is
  // counted here so that the sender keeps offering points meanwhile and the
  // block backs up into its input.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 0;
    end else begin
      m_tready = quiet ? 1'b1 : ($urandom_range(99) >= 14);
    end
  end

  // Every result transfer is checked at the rising edge where it happens.
  always @(posedge clk) begin
    dedup_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kept = m_tuser[0];
      got.table_full = m_tuser[1];
      got.x = m_tdata[27:0];
      got.y = m_tdata[55:28];
      got.z = m_tdata[83:56];
      got.frame_done = m_tlast;
      sb.check_result(got);
    end
  end

  // Offers one point and returns after its transfer. Valid stays high when the
  // next point follows without a gap.
  task automatic send_point(logic [27:0] x, logic [27:0] y, logic [27:0] z,
                            logic fe);
    if (!quiet && $urandom_range(99) < 14) begin
      s_tvalid = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata = {4'd0, z, y, x};
    s_tlast = fe;
    do @(posedge clk); while (!s_tready);
    sb.note_point(x, y, z, fe);
    if (pool_x.size() > 40) begin
      void'(pool_x.pop_front());
      void'(pool_y.pop_front());
      void'(pool_z.pop_front());
    end
    pool_x.push_back(x);
    pool_y.push_back(y);
    pool_z.push_back(z);
    @(negedge clk);
  endtask

  // Lets every expected result arrive and then idles with valid low.
  task automatic drain();
    s_tvalid = 0;
    s_tlast = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Writes the cell size while the block is idle.
  task automatic write_cell(logic [CELL_W-1:0] value);
    drain();
    cfg_we = 1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 0;
    sb.cell_um = value;
  endtask

  function automatic logic [27:0] rand_coord();
    case ($urandom_range(3))
      0: return 28'($signed($urandom_range(200000)) - 100000);
      1: return 28'($signed($urandom_range(200000000)) - 100000000);
      default: return 28'($urandom);
    endcase
  endfunction

  task automatic send_random(int n);
    logic [27:0] x, y, z;
    int k;
    repeat (n) begin
      if (pool_x.size() > 0 && $urandom_range(99) < 60) begin
        // Near an earlier point: often the same cell, sometimes its neighbor.
        k = $urandom_range(pool_x.size() - 1);
        x = pool_x[k] + 28'($signed($urandom_range(40)) - 20);
        y = pool_y[k] + 28'($signed($urandom_range(40)) - 20);
        z = pool_z[k];
      end else begin
        x = rand_coord();
        y = rand_coord();
        z = rand_coord();
      end
      send_point(x, y, z, $urandom_range(29) == 0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: reset cell size, extremes, floor division around zero,
    // duplicates, and a frame end that clears the table.
    send_point(28'h7FFFFFF, 28'h8000000, 28'd0, 0);
    send_point(28'h7FFFFFF, 28'h8000000, 28'd0, 0);
    send_point(28'd4999, 28'd0, 28'd0, 0);
    send_point(28'd0, 28'd0, 28'd0, 0);
    send_point(-28'sd1, 28'd0, 28'd0, 0);
    send_point(-28'sd5000, 28'd0, 28'd0, 0);
    send_point(-28'sd5001, 28'd0, 28'd0, 0);
    send_point(28'd100000000, -28'sd100000000, 28'd100000000, 0);
    send_point(28'd0, 28'd0, 28'd0, 1);
    send_point(28'd0, 28'd0, 28'd0, 0);
    send_point(28'd1, 28'd2, 28'd3, 1);

    // A zero cell size behaves as one micrometre.
    write_cell(0);
    send_point(28'd7, 28'd7, 28'd7, 0);
    send_point(28'd7, 28'd7, 28'd8, 0);
    send_point(-28'sd7, 28'd7, 28'd7, 1);
    write_cell(20'hFFFFF);
    send_point(28'h8000000, 28'h8000000, 28'h8000000, 0);
    send_point(28'h7FFFFFF, 28'h7FFFFFF, 28'h7FFFFFF, 0);
    send_point(28'hAAAAAAA, 28'h5555555, 28'hAAAAAAA, 1);
    write_cell(20'd1000000);
    send_point(28'd999999, -28'sd1000000, 28'd0, 0);
    send_point(28'd0, -28'sd999999, 28'd1000000, 1);

    // One frame that overflows the table: distinct cells at one micrometre,
    // then two repeats, then a new cell that can no longer be stored. The long
    // receiver hold-off falls at the start of this frame.
    write_cell(1);
    hold_req = 1;
    for (int i = 0; i < 1030; i++)
      send_point(28'(i), 28'd0, 28'd0, 0);
    send_point(28'd5, 28'd0, 28'd0, 0);
    send_point(28'd1023, 28'd0, 28'd0, 0);
    send_point(28'd2000, 28'd0, 28'd0, 1);
    send_point(28'd2000, 28'd0, 28'd0, 1);

    // Random points under several cell sizes.
    write_cell(5000);
    send_random(60);
    // The sender waits for every result before going on.
    drain();
    quiet = 1;
    send_random(50);
    quiet = 0;
    write_cell(20'($urandom_range(1, 1000000)));
    send_random(60);
    write_cell(20'($urandom_range(1, 50)));
    send_random(60);
    write_cell(20'($urandom));
    send_random(60);

    drain();
    $display("Checked %0d points in %0d frames: %0d kept, %0d repeats, %0d table overflows.",
             sb.n_checked, sb.n_frames, sb.n_kept, sb.n_dup, sb.n_full);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
